### sv/bcp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the blink code pattern generator.
// No dependencies.
package bcp_pkg;

  localparam int unsigned DIVISION_MS_DEF = 100;
  localparam logic        ACTIVE_HIGH     = 1'b1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_COUNT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD_DIVS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD_DIVS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_ON_DIVS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ON_DIVS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_AFTER_FAST = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_AFTER_SLOW = 3'd7;

  typedef enum logic [1:0] {
    PH_FAST       = 2'd0,
    PH_FAST_PAUSE = 2'd1,
    PH_SLOW       = 2'd2,
    PH_SLOW_PAUSE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [3:0] fast_count;
    logic [3:0] slow_count;
    logic [7:0] fast_period_divs;
    logic [7:0] slow_period_divs;
    logic [7:0] fast_on_divs;
    logic [7:0] slow_on_divs;
    logic [7:0] pause_after_fast;
    logic [7:0] pause_after_slow;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fast_count:       4'd0,
    slow_count:       4'd0,
    fast_period_divs: 8'd2,
    slow_period_divs: 8'd6,
    fast_on_divs:     8'd1,
    slow_on_divs:     8'd3,
    pause_after_fast: 8'd4,
    pause_after_slow: 8'd6
  };

  typedef struct packed {
    logic lit;
    logic empty;
  } seq_out_t;

endpackage

### sv/bcp_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the blink code pattern generator.
// Depends on bcp_pkg.
module bcp_cfg import bcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_FAST_COUNT:       cfg.fast_count       <= wr_data[3:0];
        REG_SLOW_COUNT:       cfg.slow_count       <= wr_data[3:0];
        REG_FAST_PERIOD_DIVS: cfg.fast_period_divs <= wr_data;
        REG_SLOW_PERIOD_DIVS: cfg.slow_period_divs <= wr_data;
        REG_FAST_ON_DIVS:     cfg.fast_on_divs     <= wr_data;
        REG_SLOW_ON_DIVS:     cfg.slow_on_divs     <= wr_data;
        REG_PAUSE_AFTER_FAST: cfg.pause_after_fast <= wr_data;
        REG_PAUSE_AFTER_SLOW: cfg.pause_after_slow <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/bcp_seq.sv
`timescale 1ns / 1ps
// Frame position sequencer: tick counting, section skipping and LED decision.
// Depends on bcp_pkg.
module bcp_seq import bcp_pkg::*; #(
  parameter int unsigned DIVISION_MS = DIVISION_MS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     tick,
  input  cfg_t     cfg,
  output seq_out_t res
);

  localparam int unsigned     MS_W    = (DIVISION_MS > 1) ? $clog2(DIVISION_MS) : 1;
  localparam logic [MS_W-1:0] MS_LAST = MS_W'(DIVISION_MS - 1);

  logic [MS_W-1:0] ms, ms_next;
  phase_t          phase, phase_next;
  logic [3:0]      idx, idx_next;
  logic [7:0]      div, div_next;

  logic       stay;
  logic       found;
  logic [7:0] d;
  logic [3:0] cnt;
  logic [7:0] per;
  logic [7:0] len;
  phase_t     cand;

  function automatic logic sec_empty(input cfg_t c, input phase_t p);
    case (p)
      PH_FAST:       return (c.fast_count == 4'd0) || (c.fast_period_divs == 8'd0);
      PH_FAST_PAUSE: return c.pause_after_fast == 8'd0;
      PH_SLOW:       return (c.slow_count == 4'd0) || (c.slow_period_divs == 8'd0);
      default:       return c.pause_after_slow == 8'd0;
    endcase
  endfunction

  always_comb begin
    ms_next = ms;
    d       = div;
    if (tick) begin
      if (ms == MS_LAST) begin
        ms_next = '0;
        d       = div + 8'd1;
      end else begin
        ms_next = ms + 1'b1;
      end
    end

    cnt = (phase == PH_FAST) ? cfg.fast_count : cfg.slow_count;
    per = (phase == PH_FAST) ? cfg.fast_period_divs : cfg.slow_period_divs;
    len = (phase == PH_FAST_PAUSE) ? cfg.pause_after_fast : cfg.pause_after_slow;

    phase_next = phase;
    idx_next   = idx;
    div_next   = d;
    stay       = 1'b0;
    case (phase)
      PH_FAST, PH_SLOW: begin
        if (idx >= cnt || per == 8'd0) begin
          stay = 1'b0;
        end else if (d >= per) begin
          div_next = '0;
          if (({1'b0, idx} + 5'd1) >= {1'b0, cnt}) begin
            stay = 1'b0;
          end else begin
            idx_next = idx + 4'd1;
            stay     = 1'b1;
          end
        end else begin
          stay = 1'b1;
        end
      end
      default: begin
        stay = d < len;
      end
    endcase

    // advance to the first section that is not empty, wrapping to this one
    found = 1'b0;
    cand  = PH_FAST;
    if (!stay) begin
      phase_next = PH_FAST;
      idx_next   = '0;
      div_next   = '0;
      for (int k = 1; k <= 4; k++) begin
        cand = phase_t'(phase + 2'(k));
        if (!found && !sec_empty(cfg, cand)) begin
          found      = 1'b1;
          phase_next = cand;
        end
      end
    end

    res.empty = !(stay || found);
    res.lit   = 1'b0;
    if (stay || found) begin
      if (phase_next == PH_FAST) begin
        res.lit = div_next < cfg.fast_on_divs;
      end else if (phase_next == PH_SLOW) begin
        res.lit = div_next < cfg.slow_on_divs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms    <= '0;
      phase <= PH_FAST;
      idx   <= '0;
      div   <= '0;
    end else if (en) begin
      ms    <= ms_next;
      phase <= phase_next;
      idx   <= idx_next;
      div   <= div_next;
    end
  end

endmodule

### sv/blink_code_pattern_generator_top.sv
`timescale 1ns / 1ps
// Top level of the blink code pattern generator: config port, sequencer, result buffer.
// Depends on bcp_pkg, bcp_cfg and bcp_seq.

// One tick request is taken in every cycle while the buffer has room, and its LED level
// is registered into the result buffer; the frame position is updated by one pass of the
// sequencer logic per request. A two-entry result buffer keeps the input open while
// a finished result waits, so requests stall only when two results are unread. The
// frame phase starts at the first fast flash after reset; there is no clearing pass.
module blink_code_pattern_generator_top import bcp_pkg::*; #(
  parameter int unsigned DIVISION_MS = DIVISION_MS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  tick,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  led_level,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  seq_out_t seq;
  logic     push, pop, lvl;
  logic [1:0] cnt;
  logic     buf0, buf1;

  assign cfg_ready = 1'b1;
  assign in_ready  = cnt != 2'd2;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign lvl       = ACTIVE_HIGH ? seq.lit : !seq.lit;

  bcp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bcp_seq #(.DIVISION_MS(DIVISION_MS)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .en   (push),
    .tick (tick),
    .cfg  (cfg),
    .res  (seq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        buf0 <= lvl;
      end else begin
        buf0 <= buf1;
        buf1 <= lvl;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        buf0 <= lvl;
      end else begin
        buf1 <= lvl;
      end
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

  assign out_valid = cnt != 2'd0;
  assign led_level = buf0;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer overflow");

  a_empty_dark: assert property (@(posedge clk) disable iff (rst)
    seq.empty |-> !seq.lit)
    else $error("empty frame lights the LED");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 2'd1)
    else $error("accepted request did not produce a result");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule
